// ===== src/imu_complementary_attitude_core_defines.svh =====
`ifndef IMU_COMPLEMENTARY_ATTITUDE_CORE_DEFINES_SVH
`define IMU_COMPLEMENTARY_ATTITUDE_CORE_DEFINES_SVH

// same-cycle implication checked on every rising edge outside reset
`define ICA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ica check failed");

// next-cycle implication checked on every rising edge outside reset
`define ICA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ica check failed");

`endif

// ===== src/ica_pkg.sv =====
`default_nettype none

package ica_pkg;

    localparam int SMP_W      = 16;
    localparam int GAIN_W     = 24;
    localparam int WEIGHT_W   = 17;
    localparam int MAG_W      = 17;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;
    localparam int ATAN_DEPTH = 24;
    localparam int STEP_IDX_W = 5;
    localparam int CRD_W      = 27;
    localparam int ANG_W      = 32;
    localparam int PROD_W     = 41;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_GAIN      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAGNITUDE_LOW  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAGNITUDE_HIGH = 4'd3;

    localparam logic [GAIN_W-1:0]   GYRO_GAIN_RST      = 24'd180224;
    localparam logic [WEIGHT_W-1:0] BLEND_WEIGHT_RST   = 17'd64225;
    localparam logic [MAG_W-1:0]    MAGNITUDE_LOW_RST  = 17'd8192;
    localparam logic [MAG_W-1:0]    MAGNITUDE_HIGH_RST = 17'd32768;

    // multiplier operand selection
    localparam logic [1:0] MUL_RATE_X = 2'd0;
    localparam logic [1:0] MUL_RATE_Y = 2'd1;
    localparam logic [1:0] MUL_WEIGHT = 2'd2;
    localparam logic [1:0] MUL_COMP   = 2'd3;

    localparam logic [WEIGHT_W-1:0]     WEIGHT_ONE = 17'd65536;
    localparam logic signed [ANG_W-1:0] HALF_TURN  = 32'sd754974720;

    typedef struct packed {
        logic signed [SMP_W-1:0] accel_x;
        logic signed [SMP_W-1:0] accel_y;
        logic signed [SMP_W-1:0] accel_z;
        logic signed [SMP_W-1:0] rate_x;
        logic signed [SMP_W-1:0] rate_y;
    } sample_t;

    typedef struct packed {
        logic                  load;
        logic                  mul_en;
        logic [1:0]            mul_sel;
        logic                  axis;
        logic                  pitch_gyro;
        logic                  roll_gyro;
        logic                  cordic_init;
        logic                  cordic_step;
        logic [STEP_IDX_W-1:0] step_idx;
        logic                  tilt_save;
        logic                  bacc_load;
        logic                  blend_save;
        logic                  commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic gate;
    } dp_status_t;

    function automatic logic [MAG_W-1:0] abs17(input logic signed [SMP_W-1:0] v);
        logic signed [MAG_W-1:0] e;
        e = {v[SMP_W-1], v};
        return e[MAG_W-1] ? MAG_W'(-e) : MAG_W'(e);
    endfunction

    function automatic logic signed [SMP_W-1:0] sat16(input logic signed [25:0] v);
        logic signed [SMP_W-1:0] r;
        if (v > 26'sd32767)
            r = 16'sh7fff;
        else if (v < -26'sd32768)
            r = 16'sh8000;
        else
            r = v[SMP_W-1:0];
        return r;
    endfunction

    // arctangent of 2^-i in degrees * 2^22
    function automatic logic signed [ANG_W-1:0] atan_entry(input logic [STEP_IDX_W-1:0] i);
        logic signed [ANG_W-1:0] r;
        case (i)
            5'd0:    r = 32'sd188743680;
            5'd1:    r = 32'sd111421900;
            5'd2:    r = 32'sd58872272;
            5'd3:    r = 32'sd29884485;
            5'd4:    r = 32'sd15000234;
            5'd5:    r = 32'sd7507429;
            5'd6:    r = 32'sd3754631;
            5'd7:    r = 32'sd1877430;
            5'd8:    r = 32'sd938729;
            5'd9:    r = 32'sd469366;
            5'd10:   r = 32'sd234683;
            5'd11:   r = 32'sd117342;
            5'd12:   r = 32'sd58671;
            5'd13:   r = 32'sd29335;
            5'd14:   r = 32'sd14668;
            5'd15:   r = 32'sd7334;
            5'd16:   r = 32'sd3667;
            5'd17:   r = 32'sd1833;
            5'd18:   r = 32'sd917;
            5'd19:   r = 32'sd458;
            5'd20:   r = 32'sd229;
            5'd21:   r = 32'sd115;
            5'd22:   r = 32'sd57;
            5'd23:   r = 32'sd29;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/ica_sample_if.sv =====
`default_nettype none

interface ica_sample_if import ica_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] accel_x;
    logic signed [SMP_W-1:0] accel_y;
    logic signed [SMP_W-1:0] accel_z;
    logic signed [SMP_W-1:0] rate_x;
    logic signed [SMP_W-1:0] rate_y;

    modport source (
        output valid, accel_x, accel_y, accel_z, rate_x, rate_y,
        input  ready
    );

    modport sink (
        input  valid, accel_x, accel_y, accel_z, rate_x, rate_y,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/ica_result_if.sv =====
`default_nettype none

interface ica_result_if import ica_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] pitch_out;
    logic signed [SMP_W-1:0] roll_out;
    logic                    accel_blended;

    modport source (
        output valid, pitch_out, roll_out, accel_blended,
        input  ready
    );

    modport sink (
        input  valid, pitch_out, roll_out, accel_blended,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/ica_cfg_if.sv =====
`default_nettype none

interface ica_cfg_if import ica_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/ica_datapath.sv =====
`default_nettype none

module ica_datapath import ica_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire ctrl_cmd_t               cmd,
    output dp_status_t                   status,
    input  wire sample_t                 sample,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data,
    output logic signed [SMP_W-1:0]      pitch_out,
    output logic signed [SMP_W-1:0]      roll_out,
    output logic                         accel_blended
);

    logic [GAIN_W-1:0]   gyro_gain_reg;
    logic [WEIGHT_W-1:0] blend_weight_reg;
    logic [MAG_W-1:0]    mag_low_reg;
    logic [MAG_W-1:0]    mag_high_reg;

    sample_t             smp_reg;
    logic                gate_reg;
    logic [MAG_W:0]      mag;
    logic                gate;

    logic signed [24:0]       mul_a;
    logic signed [SMP_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] bacc_reg;
    logic [WEIGHT_W-1:0]      w_eff;
    logic [WEIGHT_W-1:0]      w_comp;

    logic signed [PROD_W-1:0] gyro_rnd;
    logic signed [16:0]       gstep;
    logic signed [17:0]       pitch_sum;
    logic signed [17:0]       roll_diff;

    logic signed [SMP_W-1:0]  pint_reg;
    logic signed [SMP_W-1:0]  rint_reg;
    logic signed [SMP_W-1:0]  tilt_p_reg;
    logic signed [SMP_W-1:0]  tilt_r_reg;
    logic signed [SMP_W-1:0]  pitch_angle_reg;
    logic signed [SMP_W-1:0]  roll_angle_reg;
    logic                     blended_reg;

    logic signed [CRD_W-1:0]  cx_reg;
    logic signed [CRD_W-1:0]  cy_reg;
    logic signed [ANG_W-1:0]  cz_reg;
    logic                     czero_reg;

    logic signed [SMP_W-1:0]  y_in;
    logic signed [SMP_W:0]    x_ext;
    logic signed [SMP_W:0]    y_ext;
    logic signed [SMP_W:0]    x_rot;
    logic signed [SMP_W:0]    y_rot;
    logic signed [ANG_W-1:0]  z_rot;
    logic signed [CRD_W-1:0]  dx;
    logic signed [CRD_W-1:0]  dy;
    logic signed [ANG_W-1:0]  step_ang;
    logic signed [ANG_W-1:0]  z_rnd;
    logic signed [SMP_W-1:0]  tilt_val;

    logic signed [PROD_W:0]   bsum;
    logic signed [SMP_W-1:0]  blend_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gyro_gain_reg    <= GYRO_GAIN_RST;
            blend_weight_reg <= BLEND_WEIGHT_RST;
            mag_low_reg      <= MAGNITUDE_LOW_RST;
            mag_high_reg     <= MAGNITUDE_HIGH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GYRO_GAIN:      gyro_gain_reg    <= cfg_data[GAIN_W-1:0];
                REG_BLEND_WEIGHT:   blend_weight_reg <= cfg_data[WEIGHT_W-1:0];
                REG_MAGNITUDE_LOW:  mag_low_reg      <= cfg_data[MAG_W-1:0];
                REG_MAGNITUDE_HIGH: mag_high_reg     <= cfg_data[MAG_W-1:0];
                default:            ;
            endcase
        end
    end

    // accelerometer magnitude gate, open interval
    always_comb
    begin
        mag  = (MAG_W+1)'(abs17(sample.accel_x)) + (MAG_W+1)'(abs17(sample.accel_y))
             + (MAG_W+1)'(abs17(sample.accel_z));
        gate = (mag > {1'b0, mag_low_reg}) && (mag < {1'b0, mag_high_reg});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            smp_reg  <= sample;
            gate_reg <= gate;
        end
    end

    assign status.gate = gate_reg;

    // shared multiplier
    always_comb
    begin
        w_eff  = (blend_weight_reg > WEIGHT_ONE) ? WEIGHT_ONE : blend_weight_reg;
        w_comp = WEIGHT_ONE - w_eff;
        case (cmd.mul_sel)
            MUL_RATE_X:
            begin
                mul_a = {1'b0, gyro_gain_reg};
                mul_b = smp_reg.rate_x;
            end
            MUL_RATE_Y:
            begin
                mul_a = {1'b0, gyro_gain_reg};
                mul_b = smp_reg.rate_y;
            end
            MUL_WEIGHT:
            begin
                mul_a = {8'd0, w_eff};
                mul_b = cmd.axis ? rint_reg : pint_reg;
            end
            default:
            begin
                mul_a = {8'd0, w_comp};
                mul_b = cmd.axis ? tilt_r_reg : tilt_p_reg;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            prod_reg <= mul_p;
        if (cmd.bacc_load)
            bacc_reg <= prod_reg;
    end

    // gyro increment rounded to nearest, then saturating integrate
    always_comb
    begin
        gyro_rnd  = prod_reg + PROD_W'(64'sd8388608);
        gstep     = gyro_rnd[PROD_W-1:24];
        pitch_sum = {{2{pitch_angle_reg[SMP_W-1]}}, pitch_angle_reg} + {gstep[16], gstep};
        roll_diff = {{2{roll_angle_reg[SMP_W-1]}}, roll_angle_reg} - {gstep[16], gstep};
    end

    // cordic pre-rotation into the right half plane
    always_comb
    begin
        y_in  = cmd.axis ? smp_reg.accel_x : smp_reg.accel_y;
        x_ext = {smp_reg.accel_z[SMP_W-1], smp_reg.accel_z};
        y_ext = {y_in[SMP_W-1], y_in};
        if (x_ext[SMP_W])
        begin
            x_rot = -x_ext;
            y_rot = -y_ext;
            z_rot = y_in[SMP_W-1] ? -HALF_TURN : HALF_TURN;
        end
        else
        begin
            x_rot = x_ext;
            y_rot = y_ext;
            z_rot = '0;
        end
        dx       = cy_reg >>> cmd.step_idx;
        dy       = cx_reg >>> cmd.step_idx;
        step_ang = atan_entry(cmd.step_idx);
        z_rnd    = cz_reg + 32'sd32768;
        tilt_val = czero_reg ? 16'sd0 : z_rnd[ANG_W-1:16];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cordic_init)
        begin
            cx_reg    <= {{2{x_rot[SMP_W]}}, x_rot, 8'h00};
            cy_reg    <= {{2{y_rot[SMP_W]}}, y_rot, 8'h00};
            cz_reg    <= z_rot;
            czero_reg <= (x_ext == '0) && (y_ext == '0);
        end
        else if (cmd.cordic_step)
        begin
            if (cy_reg > 27'sd0)
            begin
                cx_reg <= cx_reg + dx;
                cy_reg <= cy_reg - dy;
                cz_reg <= cz_reg + step_ang;
            end
            else
            begin
                cx_reg <= cx_reg - dx;
                cy_reg <= cy_reg + dy;
                cz_reg <= cz_reg - step_ang;
            end
        end
        if (cmd.tilt_save)
        begin
            if (cmd.axis)
                tilt_r_reg <= tilt_val;
            else
                tilt_p_reg <= tilt_val;
        end
    end

    // weighted sum of integrated and tilt angle, rounded
    always_comb
    begin
        bsum      = (PROD_W+1)'(bacc_reg) + (PROD_W+1)'(prod_reg) + (PROD_W+1)'(64'sd32768);
        blend_val = sat16(bsum[PROD_W:16]);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pitch_gyro)
            pint_reg <= sat16(26'(pitch_sum));
        if (cmd.roll_gyro)
            rint_reg <= sat16(26'(roll_diff));
        if (cmd.blend_save)
        begin
            if (cmd.axis)
                rint_reg <= blend_val;
            else
                pint_reg <= blend_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_angle_reg <= '0;
            roll_angle_reg  <= '0;
            blended_reg     <= 1'b0;
        end
        else if (cmd.commit)
        begin
            pitch_angle_reg <= pint_reg;
            roll_angle_reg  <= rint_reg;
            blended_reg     <= gate_reg;
        end
    end

    assign pitch_out     = pitch_angle_reg;
    assign roll_out      = roll_angle_reg;
    assign accel_blended = blended_reg;

endmodule

`default_nettype wire

// ===== src/ica_ctrl.sv =====
`default_nettype none

module ica_ctrl import ica_pkg::*;
#(
    parameter int N_STEPS = 16
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_GX    = 4'd1;
    localparam logic [3:0] S_GY    = 4'd2;
    localparam logic [3:0] S_RG    = 4'd3;
    localparam logic [3:0] S_CINIT = 4'd4;
    localparam logic [3:0] S_CITER = 4'd5;
    localparam logic [3:0] S_CFIN  = 4'd6;
    localparam logic [3:0] S_B1    = 4'd7;
    localparam logic [3:0] S_B2    = 4'd8;
    localparam logic [3:0] S_B3    = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    localparam logic [STEP_IDX_W-1:0] LAST_STEP = STEP_IDX_W'(N_STEPS - 1);

    logic [3:0]            state_reg, state_next;
    logic                  axis_reg, axis_next;
    logic [STEP_IDX_W-1:0] cnt_reg, cnt_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.axis       = axis_reg;
        cmd.step_idx   = cnt_reg;
        cmd.mul_sel    = MUL_RATE_X;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_GX;
                end
            end
            S_GX:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_RATE_X;
                state_next  = S_GY;
            end
            S_GY:
            begin
                cmd.mul_en     = 1'b1;
                cmd.mul_sel    = MUL_RATE_Y;
                cmd.pitch_gyro = 1'b1;
                state_next     = S_RG;
            end
            S_RG:
            begin
                cmd.roll_gyro = 1'b1;
                axis_next     = 1'b0;
                state_next    = status.gate ? S_CINIT : S_OUT;
            end
            S_CINIT:
            begin
                cmd.cordic_init = 1'b1;
                cnt_next        = '0;
                state_next      = S_CITER;
            end
            S_CITER:
            begin
                cmd.cordic_step = 1'b1;
                cnt_next        = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                    state_next = S_CFIN;
            end
            S_CFIN:
            begin
                cmd.tilt_save = 1'b1;
                axis_next     = !axis_reg;
                state_next    = axis_reg ? S_B1 : S_CINIT;
            end
            S_B1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_WEIGHT;
                state_next  = S_B2;
            end
            S_B2:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MUL_COMP;
                cmd.bacc_load = 1'b1;
                state_next    = S_B3;
            end
            S_B3:
            begin
                cmd.blend_save = 1'b1;
                axis_next      = !axis_reg;
                state_next     = axis_reg ? S_OUT : S_B1;
            end
            S_OUT:
            begin
                // wait for the result register to drain before overwriting
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/imu_complementary_attitude_core.sv =====
// Complementary pitch/roll filter: each sample transfer integrates the gyro rates into the
// stored angles (1/64 degree, saturating) and, when |ax|+|ay|+|az| lies strictly between
// magnitude_low and magnitude_high, blends each angle with an accelerometer tilt from an
// iterative CORDIC atan2. A sample that fails the gate skips the CORDIC and blend states; one
// that passes runs the single CORDIC unit at one step per cycle, first for pitch then for
// roll, with the gyro and blend products all formed on the one shared multiplier. The result
// sits in an output register, so the next sample is taken while it waits; the core stalls
// only if a second result is ready before the first has been taken. Configuration writes
// are always accepted and should be issued only while no sample is in flight.
`default_nettype none

`include "imu_complementary_attitude_core_defines.svh"

module imu_complementary_attitude_core import ica_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    ica_sample_if.sink   sample,
    ica_result_if.source result,
    ica_cfg_if.sink      cfg
);

    localparam int N_STEPS = (CORDIC_STEPS > ATAN_DEPTH) ? ATAN_DEPTH : CORDIC_STEPS;

    ctrl_cmd_t  cmd;
    dp_status_t status;
    sample_t    smp;

    assign cfg.ready = 1'b1;

    assign smp.accel_x = sample.accel_x;
    assign smp.accel_y = sample.accel_y;
    assign smp.accel_z = sample.accel_z;
    assign smp.rate_x  = sample.rate_x;
    assign smp.rate_y  = sample.rate_y;

    ica_ctrl #(
        .N_STEPS (N_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    ica_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .sample        (smp),
        .cfg_we        (cfg.valid),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .pitch_out     (result.pitch_out),
        .roll_out      (result.roll_out),
        .accel_blended (result.accel_blended)
    );

    `ICA_ASSERT_NOW(a_commit_slot_free, cmd.commit, !result.valid || result.ready)
    `ICA_ASSERT_NEXT(a_busy_after_take, sample.valid && sample.ready, !sample.ready)
    `ICA_ASSERT_NOW(a_step_in_range, cmd.cordic_step, cmd.step_idx < STEP_IDX_W'(N_STEPS))
    `ICA_ASSERT_NOW(a_blend_only_gated, cmd.blend_save || cmd.cordic_init, status.gate)

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb;
    import ica_pkg::*;

    localparam int CORDIC_STEPS = 16;

    // unmapped register index, a write there must leave every register alone
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 4'd15;

    // arctangent of 2^-i in degrees * 2^22
    localparam longint ATAN_DEG22 [0:23] = '{
        188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
        3754631, 1877430, 938729, 469366, 234683, 117342,
        58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29
    };

    typedef struct packed {
        logic signed [SMP_W-1:0] pitch;
        logic signed [SMP_W-1:0] roll;
        logic                    blended;
    } attitude_t;

    typedef struct packed {
        sample_t   item;
        logic      typed;
        attitude_t want;
    } directed_row_t;

    localparam int DIRECTED_COUNT = 18;

    // want is filled in only where the answer is obvious, the rest go through the predictor
    directed_row_t directed_rows [0:DIRECTED_COUNT-1] = '{
        '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'sd0, 16'sd0, 1'b0}},
        '{'{16'sd0, 16'sd0, 16'sd0, 16'sd32767, 16'sd0}, 1'b1, '{16'sd352, 16'sd0, 1'b0}},
        '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd32768}, 1'b1, '{16'sd352, 16'sd352, 1'b0}},
        '{'{16'sd0, 16'sd0, 16'sd0, -16'sd32768, 16'sd32767}, 1'b1, '{16'sd0, 16'sd0, 1'b0}},
        // magnitude equal to the low bound, no blend
        '{'{16'sd8192, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'sd0, 16'sd0, 1'b0}},
        // magnitude equal to the high bound, no blend
        '{'{16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 16'sd0}, 1'b1, '{16'sd0, 16'sd0, 1'b0}},
        '{'{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0}, 1'b0, '0},
        // pitch operands both zero
        '{'{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
        '{'{16'sd0, -16'sd16384, -16'sd16384, 16'sd0, 16'sd0}, 1'b0, '0},
        '{'{16'sd0, 16'sd16384, -16'sd16384, 16'sd0, 16'sd0}, 1'b0, '0},
        '{'{-16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
        '{'{16'sd8193, 16'sd0, 16'sd0, 16'sd100, -16'sd100}, 1'b0, '0},
        '{'{16'sd0, 16'sd0, -16'sd32767, 16'sd0, 16'sd0}, 1'b0, '0},
        '{'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768}, 1'b0, '0},
        '{'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767}, 1'b0, '0},
        '{'{-16'sd1, -16'sd1, -16'sd1, 16'sd1, -16'sd1}, 1'b0, '0},
        '{'{16'sd4000, -16'sd6000, 16'sd10000, 16'sd1200, -16'sd900}, 1'b0, '0},
        '{'{-16'sd12000, 16'sd9000, -16'sd3000, -16'sd50, 16'sd77}, 1'b0, '0}
    };

    logic clk;
    logic rst_n;

    ica_sample_if smp();
    ica_result_if res();
    ica_cfg_if    cfg();

    imu_complementary_attitude_core #(.CORDIC_STEPS(CORDIC_STEPS)) DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (smp),
        .result (res),
        .cfg    (cfg)
    );

    // filter state and register copies
    logic signed [SMP_W-1:0] pitch_state = '0;
    logic signed [SMP_W-1:0] roll_state  = '0;
    logic [GAIN_W-1:0]       gain_q      = GYRO_GAIN_RST;
    logic [WEIGHT_W-1:0]     weight_q    = BLEND_WEIGHT_RST;
    logic [MAG_W-1:0]        low_q       = MAGNITUDE_LOW_RST;
    logic [MAG_W-1:0]        high_q      = MAGNITUDE_HIGH_RST;

    attitude_t expected_attitude [$];
    int        mismatch_count = 0;
    bit        idle_enabled   = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic signed [SMP_W-1:0] clamp16(input longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[SMP_W-1:0];
    endfunction

    function automatic longint magnitude(input logic signed [SMP_W-1:0] v);
        longint e;
        e = v;
        return (e < 0) ? -e : e;
    endfunction

    function automatic longint rate_increment(input logic signed [SMP_W-1:0] rate);
        return (longint'(rate) * longint'(gain_q) + (longint'(1) <<< 23)) >>> 24;
    endfunction

    // atan2(y, x) in 1/64 degree by vectoring rotation
    function automatic logic signed [SMP_W-1:0] tilt_angle(input longint y, input longint x);
        longint z;
        longint dx;
        longint dy;
        int     steps;
        int     i;
        z = 0;
        steps = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
        if (x == 0 && y == 0)
            return '0;
        // left half plane: rotate by half a turn first
        if (x < 0)
        begin
            z = (y < 0) ? -longint'(HALF_TURN) : longint'(HALF_TURN);
            x = -x;
            y = -y;
        end
        x = x * 256;
        y = y * 256;
        for (i = 0; i < steps; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_DEG22[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_DEG22[i];
            end
        end
        return clamp16((z + 32768) >>> 16);
    endfunction

    function automatic logic signed [SMP_W-1:0] mix_angle(input logic signed [SMP_W-1:0] integ,
                                                          input logic signed [SMP_W-1:0] accel);
        longint w;
        longint s;
        w = (weight_q > WEIGHT_ONE) ? longint'(WEIGHT_ONE) : longint'(weight_q);
        s = w * longint'(integ) + (65536 - w) * longint'(accel) + 32768;
        return clamp16(s >>> 16);
    endfunction

    function automatic attitude_t advance_attitude(input sample_t s);
        attitude_t r;
        longint    mag;
        logic      gate;
        mag = magnitude(s.accel_x) + magnitude(s.accel_y) + magnitude(s.accel_z);
        pitch_state = clamp16(longint'(pitch_state) + rate_increment(s.rate_x));
        roll_state  = clamp16(longint'(roll_state) - rate_increment(s.rate_y));
        gate = (mag > longint'(low_q)) && (mag < longint'(high_q));
        if (gate)
        begin
            pitch_state = mix_angle(pitch_state, tilt_angle(s.accel_y, s.accel_z));
            roll_state  = mix_angle(roll_state, tilt_angle(s.accel_x, s.accel_z));
        end
        r.pitch   = pitch_state;
        r.roll    = roll_state;
        r.blended = gate;
        return r;
    endfunction

    function automatic logic signed [SMP_W-1:0] pick_axis(input int span);
        int v;
        case ($urandom_range(0, 15))
            0:
            begin
                case ($urandom_range(0, 4))
                    0:       v = -32768;
                    1:       v = -1;
                    2:       v = 0;
                    3:       v = 1;
                    default: v = 32767;
                endcase
            end
            1:       v = int'($urandom_range(0, 65535)) - 32768;
            default: v = int'($urandom_range(0, 2 * span)) - span;
        endcase
        return SMP_W'(v);
    endfunction

    // mostly samples whose magnitude sum lands around the gate window
    function automatic sample_t make_sample();
        sample_t s;
        int      span;
        int      rate_span;
        span = $urandom_range(1, 12000);
        rate_span = ($urandom_range(0, 3) == 0) ? 32767 : 1500;
        s.accel_x = pick_axis(span);
        s.accel_y = pick_axis(span);
        s.accel_z = pick_axis(span);
        s.rate_x  = pick_axis(rate_span);
        s.rate_y  = pick_axis(rate_span);
        return s;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic check_attitude();
        attitude_t want;
        if (expected_attitude.size() == 0)
        begin
            report_mismatch($sformatf("result with nothing pending: pitch %0d roll %0d",
                                      res.pitch_out, res.roll_out));
            return;
        end
        want = expected_attitude.pop_front();
        if (res.pitch_out !== want.pitch)
            report_mismatch($sformatf("pitch_out %0d, expected %0d", res.pitch_out, want.pitch));
        if (res.roll_out !== want.roll)
            report_mismatch($sformatf("roll_out %0d, expected %0d", res.roll_out, want.roll));
        if (res.accel_blended !== want.blended)
            report_mismatch($sformatf("accel_blended %0b, expected %0b",
                                      res.accel_blended, want.blended));
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= index;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        case (index)
            REG_GYRO_GAIN:      gain_q   = value[GAIN_W-1:0];
            REG_BLEND_WEIGHT:   weight_q = value[WEIGHT_W-1:0];
            REG_MAGNITUDE_LOW:  low_q    = value[MAG_W-1:0];
            REG_MAGNITUDE_HIGH: high_q   = value[MAG_W-1:0];
            default:            ;
        endcase
    endtask

    // valid stays high across the back-to-back writes and drops after the last one
    task automatic program_filter(input logic [CFG_DATA_W-1:0] gain,
                                  input logic [CFG_DATA_W-1:0] weight,
                                  input logic [CFG_DATA_W-1:0] low,
                                  input logic [CFG_DATA_W-1:0] high);
        write_register(REG_GYRO_GAIN, gain);
        write_register(REG_UNMAPPED, CFG_DATA_W'($urandom));
        write_register(REG_BLEND_WEIGHT, weight);
        write_register(REG_MAGNITUDE_LOW, low);
        write_register(REG_MAGNITUDE_HIGH, high);
        cfg.valid <= 1'b0;
    endtask

    task automatic send_sample(input sample_t s, output attitude_t predicted);
        if (idle_enabled && $urandom_range(0, 3) == 0)
        begin
            smp.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        smp.valid   <= 1'b1;
        smp.accel_x <= s.accel_x;
        smp.accel_y <= s.accel_y;
        smp.accel_z <= s.accel_z;
        smp.rate_x  <= s.rate_x;
        smp.rate_y  <= s.rate_y;
        do
            @(posedge clk);
        while (!smp.ready);
        predicted = advance_attitude(s);
    endtask

    task automatic run_random(input int count, input bit allow_idle);
        attitude_t predicted;
        int        k;
        for (k = 0; k < count; k++)
        begin
            // stretches with and without idling
            if (k % 40 == 0)
                idle_enabled = allow_idle && ($urandom_range(0, 3) != 0);
            send_sample(make_sample(), predicted);
            expected_attitude.push_back(predicted);
        end
    endtask

    task automatic wait_drained();
        smp.valid <= 1'b0;
        while (expected_attitude.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : result_sink
        int  hold_left;
        bit  ready_next;
        hold_left = 0;
        res.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res.valid && res.ready)
                check_attitude();
            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else if (rst_n && idle_enabled && $urandom_range(0, 5) == 0)
            begin
                hold_left = $urandom_range(1, 9) - 1;
                ready_next = 1'b0;
            end
            else
                ready_next = rst_n;
            res.ready <= ready_next;
        end
    end

    initial
    begin : stimulus
        attitude_t predicted;
        int        r;
        int        low;
        rst_n       <= 1'b0;
        smp.valid   <= 1'b0;
        smp.accel_x <= '0;
        smp.accel_y <= '0;
        smp.accel_z <= '0;
        smp.rate_x  <= '0;
        smp.rate_y  <= '0;
        cfg.valid   <= 1'b0;
        cfg.index   <= REG_GYRO_GAIN;
        cfg.data    <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        program_filter(GYRO_GAIN_RST, BLEND_WEIGHT_RST, MAGNITUDE_LOW_RST, MAGNITUDE_HIGH_RST);
        idle_enabled = 1'b1;
        for (r = 0; r < DIRECTED_COUNT; r++)
        begin
            send_sample(directed_rows[r].item, predicted);
            expected_attitude.push_back(directed_rows[r].typed ? directed_rows[r].want : predicted);
        end
        run_random(200, 1'b1);

        // largest gain, pure gyro, widest window
        wait_drained();
        program_filter(24'hffffff, 24'd65536, 24'd0, 24'd98304);
        run_random(120, 1'b1);

        // no gyro, pure accelerometer, almost every sample blends
        wait_drained();
        program_filter(24'd0, 24'd0, 24'd0, 24'h01ffff);
        run_random(120, 1'b1);

        // oversized weight from wide data, inverted window never passes
        wait_drained();
        program_filter(CFG_DATA_W'($urandom), 24'hffffff, 24'd98304, 24'd0);
        run_random(80, 1'b1);

        // empty window with equal bounds
        wait_drained();
        program_filter(CFG_DATA_W'($urandom_range(0, 400000)), 24'd32768, 24'd20000, 24'd20000);
        run_random(60, 1'b1);

        repeat (3)
        begin
            wait_drained();
            low = $urandom_range(0, 30000);
            program_filter(CFG_DATA_W'($urandom_range(0, 1000000)),
                           CFG_DATA_W'($urandom_range(0, 65536)),
                           CFG_DATA_W'(low),
                           CFG_DATA_W'(low + $urandom_range(1, 68304)));
            run_random(80, 1'b1);
        end

        // closing stretch at full rate on both sides
        wait_drained();
        program_filter(GYRO_GAIN_RST, BLEND_WEIGHT_RST, MAGNITUDE_LOW_RST, MAGNITUDE_HIGH_RST);
        run_random(150, 1'b0);

        wait_drained();
        repeat (2 * CORDIC_STEPS + 30) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // timeout at several times the length of the slowest passing run
    initial
    begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
